### rtl/rcsfp_pkg.sv
// Shared types and constants for the RC satellite frame parser.
package rcsfp_pkg;

   localparam int DATA_W     = 8;
   localparam int TIME_W     = 32;
   localparam int GAP_W      = 16;
   localparam int CNT_W      = 16;
   localparam int IDX_W      = 4;
   localparam int VAL_W      = 12;
   localparam int WORDS_W    = 3;
   localparam int PHASE_W    = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [CSR_ADDR_W-1:0] CSR_TEN_BIT_MODE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_GAP_US = 1'd1;

   localparam logic [GAP_W-1:0] FRAME_GAP_RESET = 16'd7500;

   localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ERR_HI = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ERR_LO = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CH_HI  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CH_LO  = 3'd4;

   localparam logic [WORDS_W-1:0] WORDS_10BIT = 3'd7;
   localparam logic [WORDS_W-1:0] WORDS_11BIT = 3'd6;

   localparam logic [VAL_W-1:0] OFFSET_CH0   = 12'd338;
   localparam logic [VAL_W-1:0] OFFSET_OTHER = 12'd1024;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [DATA_W-1:0]  first_byte;
      logic [WORDS_W-1:0] words;
      logic [TIME_W-1:0]  last_time;
      logic [CNT_W-1:0]   err_count;
      logic [CNT_W-1:0]   frame_count;
   } parse_state_type;

   typedef struct packed {
      logic [CNT_W-1:0] frames_seen;
      logic [CNT_W-1:0] frame_error_count;
      logic [VAL_W-1:0] channel_value;
      logic [IDX_W-1:0] channel_index;
      logic             frame_done;
   } result_type;

endpackage

### rtl/rcsfp_decode.sv
// Per-byte frame parsing: next parser state and the decoded channel word.
module rcsfp_decode (
   input  rcsfp_pkg::parse_state_type       state_cur,
   input  logic                             ten_bit_mode,
   input  logic [rcsfp_pkg::GAP_W-1:0]      frame_gap_us,
   input  logic [rcsfp_pkg::DATA_W-1:0]     rx_byte,
   input  logic [rcsfp_pkg::TIME_W-1:0]     time_us,
   output rcsfp_pkg::parse_state_type       state_nxt,
   output rcsfp_pkg::result_type            result,
   output logic                             result_valid
);
   import rcsfp_pkg::*;

   logic [TIME_W-1:0]  gap;
   logic [PHASE_W-1:0] phase;
   logic [IDX_W-1:0]   addr;
   logic [10:0]        raw;
   logic [WORDS_W-1:0] limit;
   logic [WORDS_W-1:0] words_inc;
   logic [CNT_W-1:0]   frames_inc;
   logic               done;

   assign gap        = time_us - state_cur.last_time;
   assign phase      = (gap > {{(TIME_W-GAP_W){1'b0}}, frame_gap_us}) ? PH_ERR_HI
                                                                      : state_cur.phase;
   assign words_inc  = state_cur.words + 3'd1;
   assign frames_inc = state_cur.frame_count + 16'd1;

   always_comb begin
      if (ten_bit_mode) begin
         addr  = state_cur.first_byte[5:2];
         raw   = {state_cur.first_byte[1:0], rx_byte, 1'b0};
         limit = WORDS_10BIT;
      end else begin
         addr  = state_cur.first_byte[6:3];
         raw   = {state_cur.first_byte[2:0], rx_byte};
         limit = WORDS_11BIT;
      end
   end

   assign done = words_inc >= limit;

   assign result.channel_index     = addr;
   assign result.channel_value     = {1'b0, raw} - ((addr == '0) ? OFFSET_CH0 : OFFSET_OTHER);
   assign result.frame_error_count = state_cur.err_count;
   assign result.frame_done        = done;
   assign result.frames_seen       = done ? frames_inc : state_cur.frame_count;

   always_comb begin
      state_nxt           = state_cur;
      state_nxt.last_time = time_us;
      result_valid        = 1'b0;
      case (phase)
         PH_ERR_HI: begin
            state_nxt.first_byte = rx_byte;
            state_nxt.phase      = PH_ERR_LO;
         end
         PH_ERR_LO: begin
            state_nxt.err_count = {state_cur.first_byte, rx_byte};
            state_nxt.words     = '0;
            state_nxt.phase     = PH_CH_HI;
         end
         PH_CH_HI: begin
            state_nxt.first_byte = rx_byte;
            state_nxt.phase      = PH_CH_LO;
         end
         PH_CH_LO: begin
            state_nxt.words = words_inc;
            result_valid    = 1'b1;
            if (done) begin
               state_nxt.phase       = PH_WAIT;
               state_nxt.frame_count = frames_inc;
            end else begin
               state_nxt.phase = PH_CH_HI;
            end
         end
         default: begin
            state_nxt.phase = PH_WAIT;
         end
      endcase
   end

endmodule

### rtl/rc_satellite_frame_parser_top.sv
// A request transfer is captured in the input register, decoded, and its response is held in the result register.
// Throughput: one byte per cycle; the input register and the parser state advance
// together whenever the result register is empty or being drained.
// Reset: synchronous, active high; parser waits for a sync gap, counters and the
// last timestamp clear, registers return to 11-bit mode and a 7500 us gap.
// Bytes that close no channel word give no response transfer.
module rc_satellite_frame_parser_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rcsfp_pkg::REQ_DATA_W-1:0]    req_tdata,   // rx_byte, time_us
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcsfp_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // channel_index, channel_value,
                                                            // frame_error_count, frames_seen
   output logic                                rsp_tlast,   // frame_done
   input  logic                                csr_we,
   input  logic [rcsfp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rcsfp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rcsfp_pkg::*;

   logic                 mode_ff;
   logic [GAP_W-1:0]     gap_ff;
   logic                 in_valid_ff;
   logic [DATA_W-1:0]    in_byte_ff;
   logic [TIME_W-1:0]    in_time_ff;
   parse_state_type      state_ff;
   parse_state_type      state_in;
   result_type           res_ff;
   result_type           res_in;
   logic                 res_valid_ff;
   logic                 res_hit;
   logic                 out_free;
   logic                 advance;

   assign out_free   = !res_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   rcsfp_decode u_decode (
      .state_cur    (state_ff),
      .ten_bit_mode (mode_ff),
      .frame_gap_us (gap_ff),
      .rx_byte      (in_byte_ff),
      .time_us      (in_time_ff),
      .state_nxt    (state_in),
      .result       (res_in),
      .result_valid (res_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         gap_ff  <= FRAME_GAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TEN_BIT_MODE: mode_ff <= csr_wdata[0];
            CSR_FRAME_GAP_US: gap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[DATA_W-1:0];
         in_time_ff <= req_tdata[DATA_W +: TIME_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_WAIT;
         state_ff.first_byte  <= '0;
         state_ff.words       <= '0;
         state_ff.last_time   <= '0;
         state_ff.err_count   <= '0;
         state_ff.frame_count <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (out_free) begin
         res_valid_ff <= advance && res_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_hit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {res_ff.frames_seen, res_ff.frame_error_count,
                        res_ff.channel_value, res_ff.channel_index};
   assign rsp_tlast  = res_ff.frame_done;

endmodule
